// File: rtl/core/rtcm3_fsc_pkg.sv
// Shared types, constants and the CRC-24Q byte update for the RTCM3 frame sync unit.
`default_nettype none

package rtcm3_fsc_pkg;

  localparam logic [7:0]  PREAMBLE       = 8'hD3;
  localparam logic [7:0]  RESERVED_MASK  = 8'hFC;
  localparam logic [24:0] CRC24Q_POLY    = 25'h1864CFB;
  localparam logic [11:0] TYPE_MIN_RESET = 12'd1000;
  localparam logic [11:0] TYPE_MAX_RESET = 12'd1200;
  localparam logic [10:0] FRAME_OVERHEAD = 11'd6;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_TYPE_MIN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_TYPE_MAX = 1'b1;

  typedef struct packed {
    logic        crc_ok;
    logic [9:0]  payload_length;
    logic [11:0] msg_type;
  } result_t;

  function automatic logic [23:0] crc24q_byte(logic [23:0] crc, logic [7:0] b);
    logic [24:0] c;
    c = {1'b0, crc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC24Q_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rtcm3_fsc_framer.sv
// Frame tracker: preamble hunt, header checks, running CRC-24Q and frame result.
`default_nettype none

module rtcm3_fsc_framer (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire logic [7:0]             rx_byte,
  input  wire logic [11:0]            type_min,
  input  wire logic [11:0]            type_max,
  output logic                        res_valid,
  output rtcm3_fsc_pkg::result_t      res
);

  logic [10:0] byte_count,       byte_count_next;
  logic [10:0] frame_length,     frame_length_next;
  logic [1:0]  length_high_bits, length_high_bits_next;
  logic [15:0] type_shift,       type_shift_next;
  logic [23:0] crc_accumulator,  crc_accumulator_next;
  logic [23:0] received_crc,     received_crc_next;

  logic [23:0] crc_upd;
  logic [10:0] count_inc;
  logic [11:0] pos_plus3;
  logic [10:0] length_field;
  logic [11:0] msg_type_next;

  assign crc_upd       = rtcm3_fsc_pkg::crc24q_byte(crc_accumulator, rx_byte);
  assign count_inc     = byte_count + 11'd1;
  assign pos_plus3     = {1'b0, byte_count} + 12'd3;
  assign msg_type_next = type_shift_next[15:4];
  assign length_field  = frame_length - rtcm3_fsc_pkg::FRAME_OVERHEAD;

  always_comb begin
    byte_count_next       = byte_count;
    frame_length_next     = frame_length;
    length_high_bits_next = length_high_bits;
    type_shift_next       = type_shift;
    crc_accumulator_next  = crc_accumulator;
    received_crc_next     = received_crc;
    res_valid             = 1'b0;

    if (byte_count == 11'd0) begin
      if (rx_byte == rtcm3_fsc_pkg::PREAMBLE) begin
        crc_accumulator_next = rtcm3_fsc_pkg::crc24q_byte(24'h000000, rx_byte);
        byte_count_next      = 11'd1;
      end
    end else if (byte_count == 11'd1) begin
      if ((rx_byte & rtcm3_fsc_pkg::RESERVED_MASK) != 8'h00) begin
        byte_count_next = 11'd0;
      end else begin
        length_high_bits_next = rx_byte[1:0];
        crc_accumulator_next  = crc_upd;
        byte_count_next       = 11'd2;
      end
    end else if (byte_count == 11'd2) begin
      frame_length_next    = {1'b0, length_high_bits, rx_byte} + rtcm3_fsc_pkg::FRAME_OVERHEAD;
      crc_accumulator_next = crc_upd;
      byte_count_next      = 11'd3;
    end else begin
      if (byte_count == 11'd3) begin
        type_shift_next = {8'h00, rx_byte};
      end else if (byte_count == 11'd4) begin
        type_shift_next = {type_shift[7:0], rx_byte};
      end
      if ((byte_count == 11'd4) &&
          ((msg_type_next < type_min) || (msg_type_next > type_max))) begin
        byte_count_next = 11'd0;
      end else begin
        if (pos_plus3 < {1'b0, frame_length}) begin
          crc_accumulator_next = crc_upd;
        end else begin
          received_crc_next = {received_crc[15:0], rx_byte};
        end
        if (count_inc >= frame_length) begin
          byte_count_next = 11'd0;
          res_valid       = 1'b1;
        end else begin
          byte_count_next = count_inc;
        end
      end
    end
  end

  assign res.msg_type       = msg_type_next;
  assign res.payload_length = length_field[9:0];
  assign res.crc_ok         = (received_crc_next == crc_accumulator_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= 11'd0;
      frame_length     <= 11'd0;
      length_high_bits <= 2'd0;
      type_shift       <= 16'h0000;
      crc_accumulator  <= 24'h000000;
      received_crc     <= 24'h000000;
    end else if (step) begin
      byte_count       <= byte_count_next;
      frame_length     <= frame_length_next;
      length_high_bits <= length_high_bits_next;
      type_shift       <= type_shift_next;
      crc_accumulator  <= crc_accumulator_next;
      received_crc     <= received_crc_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtcm3_frame_sync_crc_check_unit.sv
// Top level: input register, frame tracker, result register and config registers.
// Each accepted byte waits in the input register until the output can advance; a frame result
// shows on m_tvalid after the edge that processes the frame's last byte.
// Throughput: one byte per cycle while no held result stalls; CRC-24Q update is combinational.
// Reset (rst, synchronous): clears item valids, returns to preamble hunt,
// loads type_min = 1000 and type_max = 1200.
`default_nettype none

module rtcm3_frame_sync_crc_check_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    s_tvalid,
  output logic                                         s_tready,
  input  wire logic [7:0]                              s_tdata,   // [7:0] rx_byte
  output logic                                         m_tvalid,
  input  wire logic                                    m_tready,
  output logic [23:0]                                  m_tdata,   // [11:0] msg_type,
                                                                  // [21:12] payload_length,
                                                                  // [22] crc_ok, [23] zero
  input  wire logic                                    cfg_we,
  input  wire logic [rtcm3_fsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [11:0]                             cfg_data
);

  logic                   in_valid;
  logic [7:0]             in_byte;
  logic                   advance;
  logic                   step;
  logic [11:0]            type_min;
  logic [11:0]            type_max;
  logic                   res_valid;
  rtcm3_fsc_pkg::result_t res;
  rtcm3_fsc_pkg::result_t out_res;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign m_tdata  = {1'b0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      type_min <= rtcm3_fsc_pkg::TYPE_MIN_RESET;
      type_max <= rtcm3_fsc_pkg::TYPE_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rtcm3_fsc_pkg::REG_TYPE_MIN: type_min <= cfg_data;
        rtcm3_fsc_pkg::REG_TYPE_MAX: type_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  rtcm3_fsc_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_byte   (in_byte),
    .type_min  (type_min),
    .type_max  (type_max),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rtcm3_fsc_checker.sv
// Port-level checker for the RTCM3 frame sync unit, bound to the top level.
`default_nettype none

module rtcm3_fsc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[23])
    else $error("result pad bit set");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding accepted byte");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind rtcm3_frame_sync_crc_check_unit rtcm3_fsc_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the RTCM3 frame sync and CRC-24Q check unit.
module tb;
  import rtcm3_fsc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 400;

  class rtcm3_frame_ledger;
    logic [11:0] type_lo;
    logic [11:0] type_hi;
    logic [10:0] pos;
    logic [10:0] total_len;
    logic [1:0]  len_hi;
    logic [15:0] type_bytes;
    logic [23:0] crc_run;
    logic [23:0] crc_rx;
    result_t     pending[$];
    int unsigned failures;
    int unsigned reported;

    function new();
      type_lo    = TYPE_MIN_RESET;
      type_hi    = TYPE_MAX_RESET;
      pos        = '0;
      total_len  = '0;
      len_hi     = '0;
      type_bytes = '0;
      crc_run    = '0;
      crc_rx     = '0;
      failures   = 0;
      reported   = 0;
    endfunction

    static function logic [23:0] crc24q_next(logic [23:0] crc, logic [7:0] b);
      logic [23:0] c;
      logic        fb;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
        fb = c[23] ^ b[k];
        c  = {c[22:0], 1'b0};
        if (fb) begin
          c = c ^ CRC24Q_POLY[23:0];
        end
      end
      return c;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [11:0] v);
      if (idx == REG_TYPE_MIN) begin
        type_lo = v;
      end else if (idx == REG_TYPE_MAX) begin
        type_hi = v;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      logic [11:0] t;
      logic [10:0] plen;
      result_t     r;
      if (pos == 0) begin
        if (b == PREAMBLE) begin
          crc_run = crc24q_next(24'h000000, b);
          pos     = 11'd1;
        end
        return;
      end
      if (pos == 1) begin
        if ((b & RESERVED_MASK) != 8'h00) begin
          pos = '0;
          return;
        end
        len_hi  = b[1:0];
        crc_run = crc24q_next(crc_run, b);
        pos     = 11'd2;
        return;
      end
      if (pos == 2) begin
        total_len = {1'b0, len_hi, b} + FRAME_OVERHEAD;
        crc_run   = crc24q_next(crc_run, b);
        pos       = 11'd3;
        return;
      end
      if (pos == 3) begin
        type_bytes = {8'h00, b};
      end else if (pos == 4) begin
        type_bytes = {type_bytes[7:0], b};
        t = type_bytes[15:4];
        if (t < type_lo || t > type_hi) begin
          pos = '0;
          return;
        end
      end
      if (pos + 11'd3 < total_len) begin
        crc_run = crc24q_next(crc_run, b);
      end else begin
        crc_rx = {crc_rx[15:0], b};
      end
      pos = pos + 11'd1;
      if (pos >= total_len) begin
        pos              = '0;
        plen             = total_len - FRAME_OVERHEAD;
        r.msg_type       = type_bytes[15:4];
        r.payload_length = plen[9:0];
        r.crc_ok         = (crc_rx == crc_run);
        pending.push_back(r);
      end
    endfunction

    function void check_frame(logic [23:0] d);
      result_t want;
      if (pending.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected frame result: type %0d len %0d crc_ok %0d",
                   d[11:0], d[21:12], d[22]);
        end
        return;
      end
      want = pending.pop_front();
      if (d[11:0] != want.msg_type || d[21:12] != want.payload_length ||
          d[22] != want.crc_ok || d[23] != 1'b0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("frame mismatch: expected type %0d len %0d crc_ok %0d, got type %0d len %0d crc_ok %0d pad %0d",
                   want.msg_type, want.payload_length, want.crc_ok,
                   d[11:0], d[21:12], d[22], d[23]);
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [23:0]            m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [11:0]            cfg_data = '0;

  rtcm3_frame_ledger ledger;
  int  cycles = 0;
  int  burst_left = 0;
  int  bytes_sent = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  rtcm3_frame_sync_crc_check_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      ledger.check_frame(m_tdata);
    end
  end

  initial begin : sink
    int unsigned step;
    logic [15:0] mask;
    step = 0;
    mask = 16'hFFFF;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      if (step[5:0] == 6'd0) begin
        case ($urandom_range(0, 3))
          0: mask = 16'hFFFF;
          1: mask = 16'($urandom | $urandom);
          2: mask = 16'($urandom);
          default: mask = 16'($urandom & $urandom);
        endcase
        if (mask == 16'h0000) begin
          mask = 16'h0001;
        end
      end
      m_tready <= mask[step[3:0]];
      step++;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    ledger.take_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [11:0] t, input logic [9:0] len, input bit good_crc,
                            input int cut);
    logic [7:0]  q[$];
    logic [23:0] crc;
    q.push_back(PREAMBLE);
    q.push_back({6'b000000, len[9:8]});
    q.push_back(len[7:0]);
    for (int i = 0; i < int'(len); i++) begin
      q.push_back(8'($urandom));
    end
    if (len >= 1) begin
      q[3] = t[11:4];
    end
    if (len >= 2) begin
      q[4] = {t[3:0], q[4][3:0]};
    end
    crc = '0;
    foreach (q[i]) begin
      crc = rtcm3_frame_ledger::crc24q_next(crc, q[i]);
    end
    if (!good_crc) begin
      crc = crc ^ (24'h000001 << $urandom_range(0, 23));
    end
    q.push_back(crc[23:16]);
    q.push_back(crc[15:8]);
    q.push_back(crc[7:0]);
    for (int i = 0; i < q.size(); i++) begin
      if (cut >= 0 && i >= cut) begin
        break;
      end
      send_byte(q[i]);
    end
  endtask

  task automatic send_reserved_drop();
    logic [7:0] hdr;
    hdr = 8'($urandom);
    hdr[7:2] = 6'($urandom_range(1, 63));
    send_byte(PREAMBLE);
    send_byte(hdr);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [11:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ledger.write_reg(idx, v);
  endtask

  // finish any open frame, drain results, let the pipeline empty, then write the new type range
  task automatic set_range(input logic [11:0] lo, input logic [11:0] hi);
    while (ledger.pos != 0) begin
      send_byte(8'($urandom));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(REG_TYPE_MIN, lo);
    write_reg(REG_TYPE_MAX, hi);
  endtask

  task automatic run_phase(input int target);
    int          start;
    int          pick;
    logic [11:0] t;
    logic [9:0]  len;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (ledger.type_lo <= ledger.type_hi && $urandom_range(0, 4) != 0) begin
        t = 12'($urandom_range(ledger.type_hi, ledger.type_lo));
      end else begin
        t = 12'($urandom);
      end
      len = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(25, 80)) :
                                           10'($urandom_range(0, 12));
      if (pick < 70) begin
        send_frame(t, len, $urandom_range(0, 4) != 0, -1);
      end else if (pick < 80) begin
        send_reserved_drop();
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_frame(t, len, 1'b1, $urandom_range(1, 8));
      end
    end
  endtask

  initial begin : main
    logic [11:0] lo;
    ledger = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(PREAMBLE);
    send_byte(PREAMBLE);
    send_frame(12'd1000, 10'd2, 1'b1, -1);
    send_frame(12'd1201, 10'd2, 1'b1, 5);
    send_frame(12'd1200, 10'd2, 1'b0, -1);
    set_range(12'd0, 12'd4095);
    send_frame(12'($urandom), 10'd0, 1'b1, -1);

    set_range(12'd0, 12'd4095);
    hold_req = 1'b1;
    run_phase(70);
    set_range(TYPE_MIN_RESET, TYPE_MAX_RESET);
    run_phase(60);
    set_range(12'd0, 12'd0);
    run_phase(50);
    set_range(12'd4095, 12'd4095);
    run_phase(50);
    set_range(12'd2000, 12'd1000);
    run_phase(50);
    lo = 12'($urandom_range(0, 3800));
    set_range(lo, lo + 12'($urandom_range(0, 295)));
    run_phase(60);
    set_range(12'd0, 12'd4095);
    run_phase(70);
    send_frame(12'($urandom), 10'd260, 1'b0, -1);
    send_frame(12'($urandom), 10'd3, 1'b1, -1);

    while (ledger.pos != 0) begin
      send_byte(8'($urandom));
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: files.f
rtl/core/rtcm3_fsc_pkg.sv
rtl/core/rtcm3_fsc_framer.sv
rtl/core/rtcm3_frame_sync_crc_check_unit.sv
rtl/core/rtcm3_fsc_checker.sv
tb/tb.sv
